// File: rtl/cpu_eu_pkg.sv
// ----------------------------------------------------------------------------
// cpu_eu_pkg
// shared types, operation codes and constants of the execute unit
// ----------------------------------------------------------------------------
package cpu_eu_pkg;

	localparam int KindW = 6;
	localparam int QueueDepthDefault = 2;

	typedef enum logic [KindW-1:0] {
		K_ADC = 6'd0, K_SBC = 6'd1, K_AND = 6'd2, K_ORA = 6'd3, K_EOR = 6'd4,
		K_CMP = 6'd5, K_CPX = 6'd6, K_CPY = 6'd7, K_BIT = 6'd8,
		K_LDA = 6'd9, K_LDX = 6'd10, K_LDY = 6'd11,
		K_STA = 6'd12, K_STX = 6'd13, K_STY = 6'd14,
		K_ASLM = 6'd15, K_LSRM = 6'd16, K_ROLM = 6'd17, K_RORM = 6'd18,
		K_ASLA = 6'd19, K_LSRA = 6'd20, K_ROLA = 6'd21, K_RORA = 6'd22,
		K_INC = 6'd23, K_DEC = 6'd24, K_INX = 6'd25, K_INY = 6'd26,
		K_DEX = 6'd27, K_DEY = 6'd28,
		K_TAX = 6'd29, K_TAY = 6'd30, K_TXA = 6'd31, K_TYA = 6'd32,
		K_TSX = 6'd33, K_TXS = 6'd34,
		K_BPL = 6'd35, K_BMI = 6'd36, K_BVC = 6'd37, K_BVS = 6'd38,
		K_BCC = 6'd39, K_BCS = 6'd40, K_BNE = 6'd41, K_BEQ = 6'd42,
		K_JMP = 6'd43, K_JSR = 6'd44, K_RTS = 6'd45, K_BRK = 6'd46,
		K_RTI = 6'd47, K_PHA = 6'd48, K_PHP = 6'd49, K_PLA = 6'd50,
		K_PLP = 6'd51, K_CLC = 6'd52, K_SEC = 6'd53, K_CLI = 6'd54,
		K_SEI = 6'd55, K_CLV = 6'd56, K_NOP = 6'd57
	} kind_t;

	// front-end classification
	typedef enum logic [2:0] {
		C_ALU = 3'd0, C_STORE = 3'd1, C_RMW = 3'd2, C_BRANCH = 3'd3,
		C_PUSH = 3'd4, C_FLOW = 3'd5, C_NONE = 3'd6
	} cls_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		cls_t             cls;
		logic [7:0]       operand_byte;
		logic [15:0]      target_address;
		logic [15:0]      next_pc;
	} op_t;

	localparam logic [7:0]  SpReset   = 8'hFD;
	localparam logic [7:0]  FlagMask  = 8'hD7;
	localparam logic [7:0]  FlagsRst  = 8'h04;
	localparam logic [7:0]  PushBits  = 8'h30;
	localparam logic [7:0]  StackPage = 8'h01;

endpackage

// File: rtl/cpu_eu_if.sv
// ----------------------------------------------------------------------------
// cpu_eu_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface cpu_eu_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/eight_bit_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// execute stage of a classic 8-bit processor
// ----------------------------------------------------------------------------
// One instruction enters per transfer and is classified and queued by the
// front end; the back end holds A, X, Y, SP and the status flags and produces
// one result transfer per cycle, unless the output stalls, from a registered
// output stage. Most instructions give one result; JSR gives two and BRK three
// (one per stack push), each carrying the final register values, with last on
// the final one. Sustained rate is one instruction per cycle when the output
// does not stall; JSR and BRK hold the back end until all their results go.
module eight_bit_cpu_execute_unit import cpu_eu_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	cpu_eu_if.sink   in_ch,
	cpu_eu_if.source out_ch
);
	logic q_valid, q_pop;
	op_t  q_head;

	// queue between classify and execute
	cpu_eu_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.kind(in_ch.payload.kind), .operand_byte(in_ch.payload.operand_byte),
		.target_address(in_ch.payload.target_address),
		.next_pc(in_ch.payload.next_pc),
		.q_valid, .q_pop, .q_head
	);

	// register file, alu and push sequencing
	cpu_eu_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_head,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.write_enable(out_ch.payload.write_enable),
		.write_address(out_ch.payload.write_address),
		.write_data(out_ch.payload.write_data),
		.last(out_ch.payload.last),
		.acc_out(out_ch.payload.acc_out), .x_out(out_ch.payload.x_out),
		.y_out(out_ch.payload.y_out), .sp_out(out_ch.payload.sp_out),
		.flags_out(out_ch.payload.flags_out), .new_pc(out_ch.payload.new_pc)
	);
endmodule

// File: rtl/cpu_eu_front.sv
// ----------------------------------------------------------------------------
// cpu_eu_front
// classifies incoming instructions and queues them for the back end
// ----------------------------------------------------------------------------
module cpu_eu_front import cpu_eu_pkg::*; #(
	parameter int Depth = QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [KindW-1:0] kind,
	input  logic [7:0]       operand_byte,
	input  logic [15:0]      target_address,
	input  logic [15:0]      next_pc,
	output logic             q_valid,
	input  logic             q_pop,
	output op_t              q_head
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	op_t            mem_q [Depth];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	cls_t           cls;
	logic           push;

	always_comb begin
		unique case (kind) inside
			[K_STA:K_STY]:                cls = C_STORE;
			[K_ASLM:K_RORM], K_INC, K_DEC: cls = C_RMW;
			[K_BPL:K_BEQ]:                cls = C_BRANCH;
			K_JSR, K_BRK, K_PHA, K_PHP:   cls = C_PUSH;
			K_JMP, K_RTS, K_RTI:          cls = C_FLOW;
			[K_ADC:K_BIT], [K_LDA:K_LDY], [K_ASLA:K_RORA], [K_INX:K_TXS],
			K_PLA, K_PLP, [K_CLC:K_CLV]:  cls = C_ALU;
			default:                      cls = C_NONE;
		endcase
	end

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{kind, cls, operand_byte, target_address, next_pc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");
`endif
endmodule

// File: rtl/cpu_eu_back.sv
// ----------------------------------------------------------------------------
// cpu_eu_back
// architectural registers, execution and result beat sequencing
// ----------------------------------------------------------------------------
module cpu_eu_back import cpu_eu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  op_t         q_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic        last,
	output logic [7:0]  acc_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [7:0]  sp_out,
	output logic [7:0]  flags_out,
	output logic [15:0] new_pc
);
	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [1:0] beat_q;

	// output register
	logic        ov_q, we_q, last_q;
	logic [15:0] wa_q, pc_q;
	logic [7:0]  wd_q, ao_q, xo_q, yo_q, so_q, fo_q;

	logic [7:0]  a_n, x_n, y_n, sp_n, p_n, m, r, wd, sp_w;
	logic [15:0] pc_n, ret;
	logic [8:0]  sum;
	logic [7:0]  addend;
	logic [1:0]  nbeats;
	logic        take, we, load_out, fire;
	logic [KindW-1:0] k;

	assign k = q_head.kind;
	assign m = q_head.operand_byte;
	assign ret = q_head.next_pc - 16'd1;

	always_comb begin
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		pc_n = q_head.next_pc; take = 1'b0; we = 1'b0; wd = '0; nbeats = 2'd1;
		r = '0;
		addend = (k == K_SBC) ? ~m : m;
		sum = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[0]};
		unique case (k) inside
			K_ADC, K_SBC: begin
				a_n = sum[7:0]; p_n[0] = sum[8];
				p_n[6] = ~(a_q[7] ^ addend[7]) & (a_q[7] ^ sum[7]);
				r = sum[7:0];
			end
			K_AND: begin a_n = a_q & m; r = a_n; end
			K_ORA: begin a_n = a_q | m; r = a_n; end
			K_EOR: begin a_n = a_q ^ m; r = a_n; end
			K_CMP, K_CPX, K_CPY: begin
				sum = (k == K_CMP) ? {1'b0, a_q} + {1'b0, ~m} + 9'd1 :
				      (k == K_CPX) ? {1'b0, x_q} + {1'b0, ~m} + 9'd1 :
				                     {1'b0, y_q} + {1'b0, ~m} + 9'd1;
				r = sum[7:0]; p_n[0] = sum[8];
			end
			K_BIT: begin p_n[7] = m[7]; p_n[6] = m[6]; p_n[1] = (m & a_q) == '0; end
			K_LDA: begin a_n = m; r = m; end
			K_LDX: begin x_n = m; r = m; end
			K_LDY: begin y_n = m; r = m; end
			K_STA: begin we = 1'b1; wd = a_q; end
			K_STX: begin we = 1'b1; wd = x_q; end
			K_STY: begin we = 1'b1; wd = y_q; end
			[K_ASLM:K_RORA]: begin
				logic [7:0] v;
				v = (k >= K_ASLA) ? a_q : m;
				unique case (k) inside
					K_ASLM, K_ASLA: begin r = {v[6:0], 1'b0}; p_n[0] = v[7]; end
					K_ROLM, K_ROLA: begin r = {v[6:0], p_q[0]}; p_n[0] = v[7]; end
					K_LSRM, K_LSRA: begin r = {1'b0, v[7:1]}; p_n[0] = v[0]; end
					default:        begin r = {p_q[0], v[7:1]}; p_n[0] = v[0]; end
				endcase
				if (k >= K_ASLA) a_n = r; else begin we = 1'b1; wd = r; end
			end
			K_INC: begin r = m + 8'd1; we = 1'b1; wd = r; end
			K_DEC: begin r = m - 8'd1; we = 1'b1; wd = r; end
			K_INX: begin x_n = x_q + 8'd1; r = x_n; end
			K_INY: begin y_n = y_q + 8'd1; r = y_n; end
			K_DEX: begin x_n = x_q - 8'd1; r = x_n; end
			K_DEY: begin y_n = y_q - 8'd1; r = y_n; end
			K_TAX: begin x_n = a_q; r = a_q; end
			K_TAY: begin y_n = a_q; r = a_q; end
			K_TXA: begin a_n = x_q; r = x_q; end
			K_TYA: begin a_n = y_q; r = y_q; end
			K_TSX: begin x_n = sp_q; r = sp_q; end
			K_TXS: sp_n = x_q;
			K_BPL: take = !p_q[7];
			K_BMI: take = p_q[7];
			K_BVC: take = !p_q[6];
			K_BVS: take = p_q[6];
			K_BCC: take = !p_q[0];
			K_BCS: take = p_q[0];
			K_BNE: take = !p_q[1];
			K_BEQ: take = p_q[1];
			K_JMP: pc_n = q_head.target_address;
			K_JSR: begin
				we = 1'b1; nbeats = 2'd2; sp_n = sp_q - 8'd2;
				wd = (beat_q == 2'd0) ? ret[15:8] : ret[7:0];
				pc_n = q_head.target_address;
			end
			K_RTS: begin sp_n = sp_q + 8'd2; pc_n = q_head.target_address + 16'd1; end
			K_BRK: begin
				we = 1'b1; nbeats = 2'd3; sp_n = sp_q - 8'd3;
				wd = (beat_q == 2'd0) ? q_head.next_pc[15:8] :
				     (beat_q == 2'd1) ? q_head.next_pc[7:0] : (p_q | 8'h10 | PushBits);
				p_n = p_q | 8'h14; pc_n = q_head.target_address;
			end
			K_RTI: begin
				sp_n = sp_q + 8'd3; p_n = (m & FlagMask & 8'hEF) | (p_q & 8'h10);
				pc_n = q_head.target_address;
			end
			K_PHA: begin we = 1'b1; wd = a_q; sp_n = sp_q - 8'd1; end
			K_PHP: begin we = 1'b1; wd = p_q | PushBits; sp_n = sp_q - 8'd1; end
			K_PLA: begin sp_n = sp_q + 8'd1; a_n = m; r = m; end
			K_PLP: begin sp_n = sp_q + 8'd1; p_n = m & FlagMask; end
			K_CLC: p_n[0] = 1'b0;
			K_SEC: p_n[0] = 1'b1;
			K_CLI: p_n[2] = 1'b0;
			K_SEI: p_n[2] = 1'b1;
			K_CLV: p_n[6] = 1'b0;
			default: ;
		endcase
		// z/n from result for value-producing ops
		if ((k <= K_LDY && k != K_BIT) || (k >= K_ASLM && k <= K_TSX) || k == K_PLA) begin
			p_n[1] = (r == '0);
			p_n[7] = r[7];
		end
		if (take) pc_n = q_head.next_pc + {{8{m[7]}}, m};
	end

	assign sp_w = sp_q - {6'd0, beat_q};
	assign load_out = !ov_q || out_ready;
	assign fire = q_valid && load_out;
	assign q_pop = fire && (beat_q == nbeats - 2'd1);

	always_ff @(posedge clk) begin
		if (fire) begin
			we_q   <= we;
			wa_q   <= !we ? '0 : (q_head.cls == C_PUSH) ? {StackPage, sp_w}
			                                            : q_head.target_address;
			wd_q   <= we ? wd : '0;
			last_q <= q_pop;
			ao_q <= a_n; xo_q <= x_n; yo_q <= y_n; so_q <= sp_n;
			fo_q <= p_n & FlagMask; pc_q <= pc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= SpReset; p_q <= FlagsRst;
			beat_q <= '0; ov_q <= 1'b0;
		end else begin
			if (load_out) ov_q <= q_valid;
			if (q_pop) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n & FlagMask;
				beat_q <= '0;
			end else if (fire) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	assign out_valid = ov_q;
	assign write_enable = we_q; assign write_address = wa_q; assign write_data = wd_q;
	assign last = last_q; assign acc_out = ao_q; assign x_out = xo_q; assign y_out = yo_q;
	assign sp_out = so_q; assign flags_out = fo_q; assign new_pc = pc_q;

`ifndef NO_ASSERTIONS
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q <= 2'd2) else $error("beat counter out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> $stable(wd_q) && ov_q) else $error("result lost");
	a_flags_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(p_q & ~FlagMask) == '0) else $error("unused status bits set");
`endif
endmodule
